// File: hw/rtl/vlrq_pkg.sv
// Shared types, constants and helper functions for the variable-length record ring queue.
// Used by the controller, the datapath and the top level; it depends on nothing else.
`timescale 1ns / 1ps

package vlrq_pkg;

   localparam int RING_GRANULES = 256;
   localparam int GRANULE_BYTES = 16;
   localparam int SLOT_W        = $clog2(RING_GRANULES);
   localparam int PTR_W         = SLOT_W + 1;
   localparam int GSHIFT        = $clog2(GRANULE_BYTES);
   localparam int CMD_W         = 3;
   localparam int CONTENT_W     = 16;
   localparam int OFF_W         = 8;
   localparam int STATUS_W      = 3;
   localparam int LEN_W         = 12;
   localparam int FREE_W        = 9;
   localparam int HDR_W         = LEN_W + 2;
   localparam int SPAN_W        = CONTENT_W - GSHIFT + 1;
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 32;

   localparam int FLAG_LIVE_BIT     = 0;
   localparam int FLAG_RESERVED_BIT = 1;

   localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_LIVE  = 3'd6;

   typedef struct packed {
      logic load;
      logic exec;
      logic walk_read;
      logic walk_eval;
      logic rsp_load;
   } vlrq_cmd_type;

   typedef struct packed {
      logic walk_start;
      logic walk_more;
   } vlrq_stat_type;

   // Granules taken by a record whose header holds this payload length.
   function automatic logic [PTR_W-1:0] span_of_hdr(input logic [LEN_W-1:0] len);
      logic [LEN_W:0] rounded;
      rounded = {1'b0, len} + (LEN_W + 1)'(GRANULE_BYTES - 1);
      return PTR_W'(rounded >> GSHIFT) + PTR_W'(1);
   endfunction

endpackage

// File: hw/rtl/variable_length_ring_queue_core.sv
// Top level of the variable-length record ring queue: stream ports and packing of the payload.
// Instantiates vlrq_ctrl and vlrq_dpath; depends on vlrq_pkg.
`timescale 1ns / 1ps

// The block keeps the space of a ring of 16-byte granules that holds variable-length records.
// Each transfer on the req_ channel carries one command: reserve, commit, dequeue, release or
// cancel. Each command gives exactly one transfer on the rsp_ channel with a status, the record
// offset, the record length and the free granule count after the command.
// Reserve, commit, dequeue and cancel take one header read and at most one header write: the
// request is registered, executed in the EXEC state and its response loaded into the response
// register; a new request is taken only in the idle state and only when the response register
// is free or being emptied, so no new request is taken while the last one is still executing.
// A release at the front of the ring walks the reclaimed headers one at a time, reading each
// header in the walk read state and freeing it in the walk evaluate state, and a release
// elsewhere runs like the other commands.
// Reset clears the header table valid bits at once, so no clearing pass is needed; the block
// takes requests in the first cycle after reset.
// When the receiver holds rsp_tready low, the response stays in its register and the block
// takes no further request until that response is taken.
module variable_length_ring_queue_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: command[2:0], content_length[18:3], entry_offset[26:19], zero fill.
   input  logic [vlrq_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: status[2:0], record_offset[10:3], record_length[22:11],
   // free_granules[31:23].
   output logic [vlrq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import vlrq_pkg::*;

   vlrq_cmd_type  cmd;
   vlrq_stat_type stat;

   logic [CMD_W-1:0]     req_command;
   logic [CONTENT_W-1:0] req_content_length;
   logic [OFF_W-1:0]     req_entry_offset;
   logic [STATUS_W-1:0]  rsp_status;
   logic [OFF_W-1:0]     rsp_record_offset;
   logic [LEN_W-1:0]     rsp_record_length;
   logic [FREE_W-1:0]    rsp_free_granules;

   assign req_command        = req_tdata[CMD_W-1:0];
   assign req_content_length = req_tdata[CMD_W+CONTENT_W-1:CMD_W];
   assign req_entry_offset   = req_tdata[CMD_W+CONTENT_W+OFF_W-1:CMD_W+CONTENT_W];

   assign rsp_tdata = RSP_DATA_W'({rsp_free_granules, rsp_record_length,
                                   rsp_record_offset, rsp_status});

   vlrq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   vlrq_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_command        (req_command),
      .req_content_length (req_content_length),
      .req_entry_offset   (req_entry_offset),
      .rsp_status         (rsp_status),
      .rsp_record_offset  (rsp_record_offset),
      .rsp_record_length  (rsp_record_length),
      .rsp_free_granules  (rsp_free_granules)
   );

endmodule

// File: hw/rtl/vlrq_ctrl.sv
// Sequencing state machine of the ring queue: accepts a transfer, runs the update and walk.
// Depends on vlrq_pkg for the command and status structs.
`timescale 1ns / 1ps

module vlrq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  vlrq_pkg::vlrq_stat_type stat,
   output vlrq_pkg::vlrq_cmd_type  cmd
);
   import vlrq_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_EXEC    = 2'd1;
   localparam logic [1:0] S_WALK_RD = 2'd2;
   localparam logic [1:0] S_WALK_EV = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = !reset && (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.load      = accept;
      cmd.exec      = (state_ff == S_EXEC);
      cmd.walk_read = (state_ff == S_WALK_RD);
      cmd.walk_eval = (state_ff == S_WALK_EV);
      cmd.rsp_load  = ((state_ff == S_EXEC) && !stat.walk_start) ||
                      ((state_ff == S_WALK_EV) && !stat.walk_more);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.walk_start ? S_WALK_RD : S_IDLE;
         end
         S_WALK_RD: begin
            state_in = S_WALK_EV;
         end
         S_WALK_EV: begin
            state_in = stat.walk_more ? S_WALK_RD : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/vlrq_dpath.sv
// Datapath of the ring queue: header table, ring pointers, free space and response registers.
// Depends on vlrq_pkg; driven by the command struct from vlrq_ctrl.
`timescale 1ns / 1ps

module vlrq_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vlrq_pkg::vlrq_cmd_type                cmd,
   output vlrq_pkg::vlrq_stat_type               stat,
   input  logic [vlrq_pkg::CMD_W-1:0]            req_command,
   input  logic [vlrq_pkg::CONTENT_W-1:0]        req_content_length,
   input  logic [vlrq_pkg::OFF_W-1:0]            req_entry_offset,
   output logic [vlrq_pkg::STATUS_W-1:0]         rsp_status,
   output logic [vlrq_pkg::OFF_W-1:0]            rsp_record_offset,
   output logic [vlrq_pkg::LEN_W-1:0]            rsp_record_length,
   output logic [vlrq_pkg::FREE_W-1:0]           rsp_free_granules
);
   import vlrq_pkg::*;

   logic [CMD_W-1:0]     cmd_ff;
   logic [CONTENT_W-1:0] len_ff;
   logic [SLOT_W-1:0]    off_ff;

   logic [HDR_W-1:0]         mem [RING_GRANULES];
   logic [RING_GRANULES-1:0] valid_ff;
   logic [HDR_W-1:0]         rd_data_ff;
   logic                     rd_valid_ff;
   logic                     rd_en;
   logic [SLOT_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [SLOT_W-1:0]        wr_addr;
   logic [HDR_W-1:0]         wr_data;

   logic [PTR_W-1:0] back_ff, back_in;
   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] dq_ff, dq_in;
   logic [PTR_W-1:0] space_ff, space_in;
   logic [PTR_W-1:0] steps_ff, steps_in;
   logic             cancel_ff, cancel_in;

   logic [STATUS_W-1:0] status_in;
   logic [OFF_W-1:0]    roff_in;
   logic [LEN_W-1:0]    rlen_in;

   logic [HDR_W-1:0]     hdr;
   logic [LEN_W-1:0]     hdr_len;
   logic [CONTENT_W:0]   res_round;
   logic [SPAN_W-1:0]    res_span;
   logic [PTR_W-1:0]     hdr_span;
   logic [PTR_W:0]       space_sum;

   assign hdr       = rd_valid_ff ? rd_data_ff : '0;
   assign hdr_len   = hdr[HDR_W-1:2];
   assign hdr_span  = span_of_hdr(hdr_len);
   assign res_round = {1'b0, len_ff} + (CONTENT_W + 1)'(GRANULE_BYTES - 1);
   assign res_span  = SPAN_W'(res_round >> GSHIFT) + SPAN_W'(1);
   assign space_sum = {1'b0, space_ff} + {1'b0, hdr_span};

   assign stat.walk_start = (cmd_ff == CMD_RELEASE) && (off_ff == front_ff[SLOT_W-1:0]);
   assign stat.walk_more  = (front_ff != dq_ff) && (steps_ff != PTR_W'(RING_GRANULES)) &&
                            (hdr[FLAG_RESERVED_BIT:FLAG_LIVE_BIT] == 2'b00) &&
                            (hdr_len != '0);

   assign rd_en = cmd.load || cmd.walk_read;

   always_comb begin
      if (cmd.walk_read) begin
         rd_addr = front_ff[SLOT_W-1:0];
      end else if (req_command == CMD_DEQUEUE) begin
         rd_addr = dq_ff[SLOT_W-1:0];
      end else begin
         rd_addr = SLOT_W'(req_entry_offset);
      end
   end

   always_comb begin
      back_in   = back_ff;
      front_in  = front_ff;
      dq_in     = dq_ff;
      space_in  = space_ff;
      steps_in  = steps_ff;
      cancel_in = cancel_ff;
      status_in = ST_OK;
      roff_in   = '0;
      rlen_in   = '0;
      wr_en     = 1'b0;
      wr_addr   = off_ff;
      wr_data   = '0;
      if (cmd.exec) begin
         steps_in = '0;
         case (cmd_ff)
            CMD_RESERVE: begin
               if (len_ff == '0) begin
                  status_in = ST_ZERO_LEN;
               end else if (res_span > SPAN_W'(RING_GRANULES)) begin
                  status_in = ST_TOO_BIG;
               end else if (cancel_ff) begin
                  status_in = ST_CANCELLED;
               end else if (SPAN_W'(space_ff) < res_span) begin
                  status_in = ST_FULL;
               end else begin
                  roff_in  = OFF_W'(back_ff[SLOT_W-1:0]);
                  wr_en    = 1'b1;
                  wr_addr  = back_ff[SLOT_W-1:0];
                  wr_data  = {len_ff[LEN_W-1:0], 2'b00};
                  wr_data[FLAG_RESERVED_BIT] = 1'b1;
                  back_in  = back_ff + PTR_W'(res_span);
                  space_in = space_ff - PTR_W'(res_span);
               end
            end
            CMD_COMMIT: begin
               if (hdr_len != '0) begin
                  wr_en   = 1'b1;
                  wr_data = hdr;
                  wr_data[FLAG_LIVE_BIT] = 1'b1;
               end
            end
            CMD_DEQUEUE: begin
               if (cancel_ff) begin
                  status_in = ST_CANCELLED;
               end else if (dq_ff == back_ff) begin
                  status_in = ST_EMPTY;
               end else if (!hdr[FLAG_LIVE_BIT]) begin
                  status_in = ST_NOT_LIVE;
               end else begin
                  roff_in = OFF_W'(dq_ff[SLOT_W-1:0]);
                  rlen_in = hdr_len;
                  dq_in   = dq_ff + hdr_span;
               end
            end
            CMD_RELEASE: begin
               wr_en   = 1'b1;
               wr_data = {hdr_len, 2'b00};
            end
            CMD_CANCEL: begin
               cancel_in = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (cmd.walk_eval && stat.walk_more) begin
         wr_en    = 1'b1;
         wr_addr  = front_ff[SLOT_W-1:0];
         wr_data  = '0;
         front_in = front_ff + hdr_span;
         space_in = (space_sum > (PTR_W + 1)'(RING_GRANULES)) ? PTR_W'(RING_GRANULES)
                                                              : space_sum[PTR_W-1:0];
         steps_in = steps_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         len_ff <= req_content_length;
         off_ff <= SLOT_W'(req_entry_offset);
      end
      if (cmd.rsp_load) begin
         rsp_status        <= status_in;
         rsp_record_offset <= roff_in;
         rsp_record_length <= rlen_in;
         rsp_free_granules <= FREE_W'(space_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         back_ff   <= '0;
         front_ff  <= '0;
         dq_ff     <= '0;
         space_ff  <= PTR_W'(RING_GRANULES);
         steps_ff  <= '0;
         cancel_ff <= 1'b0;
      end else begin
         back_ff   <= back_in;
         front_ff  <= front_in;
         dq_ff     <= dq_in;
         space_ff  <= space_in;
         steps_ff  <= steps_in;
         cancel_ff <= cancel_in;
      end
   end

`ifndef SYNTH
   a_space_bound: assert property (@(posedge clock) disable iff (reset)
      space_ff <= PTR_W'(RING_GRANULES))
      else $error("free space exceeds the ring size");

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_eval |-> $past(cmd.walk_read))
      else $error("walk evaluation without a preceding header read");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_eval && stat.walk_more) |=> (steps_ff == $past(steps_ff) + PTR_W'(1)))
      else $error("walk step counter did not advance");

   a_front_moves_in_walk: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(cmd.walk_eval)) |-> $stable(front_ff))
      else $error("front pointer moved outside a reclaim walk");
`endif

endmodule

// File: test/vlrq_ring_checker.sv
// Watches both stream channels of the record ring queue, predicts every response from the
// commands it sees accepted and compares them field by field. Depends on vlrq_pkg.
`timescale 1ns / 1ps

module vlrq_ring_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [vlrq_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [vlrq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              fail_count,
   output int                              pending_count
);
   import vlrq_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    offset;
      logic [LEN_W-1:0]    length;
      logic [FREE_W-1:0]   free;
   } ring_answer_type;

   ring_answer_type  answers_due[$];
   logic [HDR_W-1:0] header_mem [RING_GRANULES];
   logic [PTR_W-1:0] back_pos;
   logic [PTR_W-1:0] front_pos;
   logic [PTR_W-1:0] deq_pos;
   int unsigned      space_free;
   logic             cancelled;

   function automatic int unsigned granule_span(input int unsigned len);
      return 1 + (len + GRANULE_BYTES - 1) / GRANULE_BYTES;
   endfunction

   function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] p,
                                                 input int unsigned n);
      int unsigned sum;
      sum = 32'(p) + n;
      return PTR_W'(sum % (2 * RING_GRANULES));
   endfunction

   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [CONTENT_W-1:0] len,
                                input logic [OFF_W-1:0] off, output ring_answer_type ans);
      int unsigned      span;
      int unsigned      steps;
      int unsigned      hlen;
      logic [SLOT_W-1:0] s;
      logic [HDR_W-1:0] h;
      logic             done;
      ans = '0;
      case (cmd)
         CMD_RESERVE: begin
            span = granule_span(32'(len));
            if (len == 0) begin
               ans.status = ST_ZERO_LEN;
            end else if (span > RING_GRANULES) begin
               ans.status = ST_TOO_BIG;
            end else if (cancelled) begin
               ans.status = ST_CANCELLED;
            end else if (space_free < span) begin
               ans.status = ST_FULL;
            end else begin
               s = back_pos[SLOT_W-1:0];
               ans.offset = s;
               h = '0;
               h[HDR_W-1:2] = len[LEN_W-1:0];
               h[FLAG_RESERVED_BIT] = 1'b1;
               header_mem[s] = h;
               back_pos = ring_step(back_pos, span);
               space_free = space_free - span;
            end
         end
         CMD_COMMIT: begin
            if (header_mem[off][HDR_W-1:2] != 0) header_mem[off][FLAG_LIVE_BIT] = 1'b1;
         end
         CMD_DEQUEUE: begin
            if (cancelled) begin
               ans.status = ST_CANCELLED;
            end else if (deq_pos == back_pos) begin
               ans.status = ST_EMPTY;
            end else begin
               s = deq_pos[SLOT_W-1:0];
               h = header_mem[s];
               if (!h[FLAG_LIVE_BIT]) begin
                  ans.status = ST_NOT_LIVE;
               end else begin
                  ans.offset = s;
                  ans.length = h[HDR_W-1:2];
                  deq_pos = ring_step(deq_pos, granule_span(32'(h[HDR_W-1:2])));
               end
            end
         end
         CMD_RELEASE: begin
            header_mem[off][FLAG_LIVE_BIT]     = 1'b0;
            header_mem[off][FLAG_RESERVED_BIT] = 1'b0;
            if (off == front_pos[SLOT_W-1:0]) begin
               steps = 0;
               done  = 1'b0;
               while (!done && front_pos != deq_pos && steps < RING_GRANULES) begin
                  s    = front_pos[SLOT_W-1:0];
                  h    = header_mem[s];
                  hlen = 32'(h[HDR_W-1:2]);
                  if (h[FLAG_LIVE_BIT] || h[FLAG_RESERVED_BIT] || hlen == 0) begin
                     done = 1'b1;
                  end else begin
                     span = granule_span(hlen);
                     header_mem[s] = '0;
                     front_pos = ring_step(front_pos, span);
                     space_free = space_free + span;
                     if (space_free > RING_GRANULES) space_free = RING_GRANULES;
                     steps++;
                  end
               end
            end
         end
         CMD_CANCEL: begin
            cancelled = 1'b1;
         end
         default: begin
         end
      endcase
      ans.free = space_free[FREE_W-1:0];
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      ring_answer_type due;
      ring_answer_type made;
      if (reset) begin
         answers_due.delete();
         for (int i = 0; i < RING_GRANULES; i++) header_mem[i] = '0;
         back_pos   = '0;
         front_pos  = '0;
         deq_pos    = '0;
         space_free = RING_GRANULES;
         cancelled  = 1'b0;
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: response transfer with none expected, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               due = answers_due.pop_front();
               check_field("status", 32'(due.status), 32'(rsp_tdata[2:0]));
               check_field("record_offset", 32'(due.offset), 32'(rsp_tdata[10:3]));
               check_field("record_length", 32'(due.length), 32'(rsp_tdata[22:11]));
               check_field("free_granules", 32'(due.free), 32'(rsp_tdata[31:23]));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_command(req_tdata[2:0], req_tdata[18:3], req_tdata[26:19], made);
            answers_due.push_back(made);
         end
      end
      pending_count = answers_due.size();
   end

endmodule

// File: test/variable_length_ring_queue_core_tb.sv
// Top of the record ring queue testbench: clock, reset, command stimulus and the verdict.
// Instantiates variable_length_ring_queue_core and vlrq_ring_checker; depends on vlrq_pkg.
`timescale 1ns / 1ps

module variable_length_ring_queue_core_tb;
   import vlrq_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    fail_count;
   int                    pending_count;

   logic                  quiet = 1'b0;
   int                    stall_left = 0;
   logic [CMD_W-1:0]      sent_cmds[$];
   logic [OFF_W-1:0]      open_records[$];
   logic [OFF_W-1:0]      taken_records[$];

   variable_length_ring_queue_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   vlrq_ring_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [CONTENT_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return CONTENT_W'($urandom_range(1, 64));
      if (r < 88) return CONTENT_W'($urandom_range(65, 600));
      if (r < 94) return CONTENT_W'($urandom_range(601, 4080));
      if (r < 96) return 16'd4080;
      if (r < 97) return 16'd0;
      return CONTENT_W'($urandom_range(0, 65535));
   endfunction

   initial begin
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = gap_len();
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Learn record offsets from the responses so that commits and releases hit real records.
   always @(posedge clock) begin
      logic [CMD_W-1:0] cmd;
      if (!reset && rsp_tvalid && rsp_tready && sent_cmds.size() > 0) begin
         cmd = sent_cmds.pop_front();
         if (rsp_tdata[2:0] == ST_OK) begin
            if (cmd == CMD_RESERVE) begin
               open_records.push_back(rsp_tdata[10:3]);
            end else if (cmd == CMD_DEQUEUE) begin
               for (int k = 0; k < open_records.size(); k++) begin
                  if (open_records[k] == rsp_tdata[10:3]) begin
                     open_records.delete(k);
                     break;
                  end
               end
               taken_records.push_back(rsp_tdata[10:3]);
            end
         end
      end
   end

   task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [CONTENT_W-1:0] len,
                               input logic [OFF_W-1:0] off);
      int n;
      req_tdata  <= {5'b0, off, len, cmd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_cmds.push_back(cmd);
      n = quiet ? 0 : gap_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   task automatic send_random_command();
      int               r;
      int               idx;
      logic [OFF_W-1:0] off;
      r   = $urandom_range(0, 99);
      off = OFF_W'($urandom_range(0, 255));
      if (r < 30) begin
         push_request(CMD_RESERVE, pick_length(), OFF_W'($urandom_range(0, 255)));
      end else if (r < 52) begin
         if (open_records.size() > 0 && $urandom_range(0, 9) != 0) begin
            off = open_records[$urandom_range(0, open_records.size() - 1)];
         end
         push_request(CMD_COMMIT, CONTENT_W'($urandom_range(0, 65535)), off);
      end else if (r < 74) begin
         push_request(CMD_DEQUEUE, CONTENT_W'($urandom_range(0, 65535)),
                      OFF_W'($urandom_range(0, 255)));
      end else if (r < 95) begin
         if (taken_records.size() > 0 && $urandom_range(0, 99) < 85) begin
            idx = $urandom_range(0, 1) ? 0 : $urandom_range(0, taken_records.size() - 1);
            off = taken_records[idx];
            taken_records.delete(idx);
         end else if (open_records.size() > 0 && $urandom_range(0, 1)) begin
            off = open_records[$urandom_range(0, open_records.size() - 1)];
         end
         push_request(CMD_RELEASE, CONTENT_W'($urandom_range(0, 65535)), off);
      end else if ($urandom_range(0, 99) < 40) begin
         push_request(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                      CONTENT_W'($urandom_range(0, 65535)), off);
      end else begin
         push_request($urandom_range(0, 1) ? CMD_COMMIT : CMD_RELEASE,
                      CONTENT_W'($urandom_range(0, 65535)), off);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Rejections, a record filling the whole ring, then a release walk over three records.
      push_request(CMD_RESERVE, 16'd0, 8'd0);
      push_request(CMD_RESERVE, 16'd4081, 8'd0);
      push_request(CMD_RESERVE, 16'hFFFF, 8'd0);
      push_request(CMD_RESERVE, 16'd4080, 8'd0);
      push_request(CMD_RESERVE, 16'd1, 8'd0);
      push_request(CMD_DEQUEUE, 16'd0, 8'd0);
      push_request(CMD_COMMIT, 16'd0, 8'd0);
      push_request(CMD_DEQUEUE, 16'd0, 8'd0);
      push_request(CMD_DEQUEUE, 16'd0, 8'd0);
      push_request(CMD_RELEASE, 16'd0, 8'd0);
      push_request(CMD_RESERVE, 16'd16, 8'd0);
      push_request(CMD_RESERVE, 16'd1, 8'd0);
      push_request(CMD_RESERVE, 16'd17, 8'd0);
      push_request(CMD_COMMIT, 16'd0, 8'd0);
      push_request(CMD_COMMIT, 16'd0, 8'd2);
      push_request(CMD_COMMIT, 16'd0, 8'd4);
      push_request(CMD_DEQUEUE, 16'd0, 8'd0);
      push_request(CMD_DEQUEUE, 16'd0, 8'd0);
      push_request(CMD_DEQUEUE, 16'd0, 8'd0);
      push_request(CMD_RELEASE, 16'd0, 8'd2);
      push_request(CMD_RELEASE, 16'd0, 8'd4);
      push_request(CMD_RELEASE, 16'd0, 8'd0);
      push_request(CMD_COMMIT, 16'd0, 8'd255);
      push_request(CMD_UNUSED_LO, 16'hA5A5, 8'h5A);
      push_request(CMD_UNUSED_HI, 16'h5A5A, 8'hA5);

      hold_until_drained();
      open_records.delete();
      taken_records.delete();

      for (int i = 0; i < 405; i++) begin
         if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (i == 200) hold_until_drained();
         send_random_command();
      end

      quiet = 1'b0;
      push_request(CMD_CANCEL, CONTENT_W'($urandom_range(0, 65535)),
                   OFF_W'($urandom_range(0, 255)));
      repeat (20) send_random_command();

      quiet = 1'b1;
      hold_until_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
